FILE: sv/drtr_pkg.sv
// Shared types, constants and the CORDIC arctangent table for the tracking-error block.
package drtr_pkg;

  // Event kinds carried in the mode field
  localparam logic [1:0] ModeVel   = 2'd0;
  localparam logic [1:0] ModeOdom  = 2'd1;
  localparam logic [1:0] ModeTruth = 2'd2;
  localparam logic [1:0] ModeTick  = 2'd3;

  // Error source codes
  localparam logic [1:0] SrcHold = 2'd0;
  localparam logic [1:0] SrcEst  = 2'd1;
  localparam logic [1:0] SrcOdom = 2'd2;

  // Register indexes, taken from paddr bit 2
  localparam logic RegTimeStep     = 1'b0;
  localparam logic RegSourceSelect = 1'b1;

  localparam logic [23:0] TimeStepReset = 24'd559241;
  localparam logic [1:0]  SourceReset   = SrcEst;

  // Angles in Q3.29, CORDIC vectors in Q1.30
  localparam logic signed [32:0] PiQ     = 33'sd1686629713;
  localparam logic signed [32:0] HalfPiQ = 33'sd843314857;
  localparam logic signed [32:0] CordicK = 33'sd652032874;
  localparam logic [31:0]        TwoPiQ  = 32'd3373259426;
  localparam logic [4:0]         CordicLast = 5'd23;
  localparam logic [47:0]        AccumMax = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [23:0] lin_speed;
    logic signed [23:0] ang_speed;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
  } in_word_t;

  typedef struct packed {
    logic [31:0] track_error;
    logic [47:0] error_total;
  } out_word_t;

  typedef struct packed {
    logic        start;
    logic [63:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] root;
  } sqrt_rsp_t;

  // Arctangent of 2^-i in Q3.29
  function automatic logic signed [32:0] atan_entry(logic [4:0] idx);
    logic signed [32:0] a;
    unique case (idx)
      5'd0:  a = 33'sd421657428;
      5'd1:  a = 33'sd248918915;
      5'd2:  a = 33'sd131521918;
      5'd3:  a = 33'sd66762579;
      5'd4:  a = 33'sd33510843;
      5'd5:  a = 33'sd16771758;
      5'd6:  a = 33'sd8387925;
      5'd7:  a = 33'sd4194219;
      5'd8:  a = 33'sd2097141;
      5'd9:  a = 33'sd1048575;
      5'd10: a = 33'sd524288;
      5'd11: a = 33'sd262144;
      5'd12: a = 33'sd131072;
      5'd13: a = 33'sd65536;
      5'd14: a = 33'sd32768;
      5'd15: a = 33'sd16384;
      5'd16: a = 33'sd8192;
      5'd17: a = 33'sd4096;
      5'd18: a = 33'sd2048;
      5'd19: a = 33'sd1024;
      5'd20: a = 33'sd512;
      5'd21: a = 33'sd256;
      5'd22: a = 33'sd128;
      5'd23: a = 33'sd64;
      default: a = 33'sd0;
    endcase
    return a;
  endfunction

endpackage

FILE: sv/drtr_isqrt.sv
// Bit-serial integer square root, two radicand bits per cycle.
module drtr_isqrt (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  drtr_pkg::sqrt_req_t req_i,
  output drtr_pkg::sqrt_rsp_t rsp_o
);

  logic [63:0] rad_q, rad_d;
  logic [33:0] rem_q, rem_d;
  logic [31:0] root_q, root_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [35:0] rem_shift;
  logic [35:0] trial;

  // Bring in the next digit pair and try the next root bit
  always_comb begin
    rem_shift = {rem_q, rad_q[63:62]};
    trial     = {2'b00, root_q, 2'b01};
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rad_d  = req_i.radicand;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = 6'd32;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d = {rad_q[61:0], 2'b00};
      if (rem_shift >= trial) begin
        rem_d  = 34'(rem_shift - trial);
        root_d = {root_q[30:0], 1'b1};
      end else begin
        rem_d  = rem_shift[33:0];
        root_d = {root_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.root = root_q;

endmodule

FILE: sv/dead_reckoning_tracking_error_top.sv
// Top level of the dead-reckoning tracking-error monitor.
//
//  channel  dir  handshake              payload
//  in       in   in_valid_i/in_stall_o  drtr_pkg::in_word_t
//  out      out  out_valid_o/out_stall_i drtr_pkg::out_word_t
//  cfg      in   APB psel/penable       time_step (0x0), source_select (0x4)
//
// Odometry and truth words are taken in the idle state. A velocity word runs one
// multiply, 24 CORDIC iterations, three product steps and eight heading wrap
// steps. A tick with an estimate or odometry source waits on the bit-serial square root.
// Reset clears the state and tracking registers and loads the registers with their defaults.
// A result waits in the output register while out_stall_i is high; the next word
// is taken meanwhile, and a following tick holds at its last step until it drains.
module dead_reckoning_tracking_error_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  drtr_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output drtr_pkg::out_word_t out_word_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_VMUL   = 4'd1;
  localparam logic [3:0] S_CORD   = 4'd2;
  localparam logic [3:0] S_MX     = 4'd3;
  localparam logic [3:0] S_MY     = 4'd4;
  localparam logic [3:0] S_EY     = 4'd5;
  localparam logic [3:0] S_HNEG   = 4'd6;
  localparam logic [3:0] S_HRED   = 4'd7;
  localparam logic [3:0] S_TDIFF  = 4'd8;
  localparam logic [3:0] S_TSQX   = 4'd9;
  localparam logic [3:0] S_TSQY   = 4'd10;
  localparam logic [3:0] S_TSTART = 4'd11;
  localparam logic [3:0] S_TROOT  = 4'd12;
  localparam logic [3:0] S_TACC   = 4'd13;

  logic [3:0] state_q, state_d;

  logic [23:0]        time_step_q, time_step_d;
  logic [1:0]         src_q, src_d;
  logic signed [31:0] est_x_q, est_x_d, est_y_q, est_y_d, heading_q, heading_d;
  logic signed [23:0] lin_q, lin_d, ang_q, ang_d;
  logic signed [31:0] odom_x_q, odom_x_d, odom_y_q, odom_y_d;
  logic signed [31:0] truth_x_q, truth_x_d, truth_y_q, truth_y_d;
  logic [31:0]        held_q, held_d;
  logic [47:0]        accum_q, accum_d;
  logic               out_valid_q, out_valid_d;
  drtr_pkg::out_word_t out_word_q, out_word_d;

  logic signed [24:0] step_q, step_d;
  logic signed [37:0] dh_q, dh_d;
  logic signed [32:0] cx_q, cx_d, cy_q, cy_d, cz_q, cz_d;
  logic               neg_q, neg_d;
  logic [4:0]         iter_q, iter_d;
  logic signed [57:0] prod_q, prod_d;
  logic signed [39:0] h_q, h_d;
  logic [2:0]         k_q, k_d;
  logic [31:0]        ux_q, ux_d, uy_q, uy_d;
  logic [63:0]        sx_q, sx_d;
  logic [64:0]        n_q, n_d;

  drtr_pkg::sqrt_req_t sqrt_req;
  drtr_pkg::sqrt_rsp_t sqrt_rsp;

  logic               in_take, out_take, cfg_wr;
  logic signed [48:0] lin_prod, ang_prod;
  logic signed [32:0] hd_ext, cval, sval, xsh, ysh;
  logic signed [27:0] inc;
  logic signed [33:0] est_sum;
  logic signed [39:0] tsh;
  logic signed [32:0] ax, ay, dx, dy;
  logic [48:0]        acc_sum;

  function automatic logic signed [31:0] sat32(logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sh0_7FFF_FFFF)       r = 32'sh7FFF_FFFF;
    else if (v < -34'sh0_8000_0000) r = 32'sh8000_0000;
    else                            r = v[31:0];
    return r;
  endfunction

  assign in_take  = in_valid_i && !in_stall_o;
  assign out_take = out_valid_q && !out_stall_i;
  assign cfg_wr   = psel && penable && pwrite && pready;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;
  assign pready      = 1'b1;
  assign prdata = (paddr[2] == drtr_pkg::RegSourceSelect) ? {30'd0, src_q}
                                                           : {8'd0, time_step_q};

  drtr_isqrt u_isqrt (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (sqrt_req),
    .rsp_o (sqrt_rsp)
  );

  // Sequence one word through the shared units
  always_comb begin
    state_d = state_q;
    time_step_d = time_step_q;
    src_d = src_q;
    est_x_d = est_x_q;  est_y_d = est_y_q;  heading_d = heading_q;
    lin_d = lin_q;  ang_d = ang_q;
    odom_x_d = odom_x_q;  odom_y_d = odom_y_q;
    truth_x_d = truth_x_q;  truth_y_d = truth_y_q;
    held_d = held_q;  accum_d = accum_q;
    out_valid_d = out_valid_q && !out_take;
    out_word_d = out_word_q;
    step_d = step_q;  dh_d = dh_q;
    cx_d = cx_q;  cy_d = cy_q;  cz_d = cz_q;  neg_d = neg_q;  iter_d = iter_q;
    prod_d = prod_q;  h_d = h_q;  k_d = k_q;
    ux_d = ux_q;  uy_d = uy_q;  sx_d = sx_q;  n_d = n_q;
    sqrt_req.start = 1'b0;
    sqrt_req.radicand = n_q[63:0];

    lin_prod = lin_q * $signed({1'b0, time_step_q});
    ang_prod = ang_q * $signed({1'b0, time_step_q});
    hd_ext   = 33'(heading_q);
    cval     = neg_q ? -cx_q : cx_q;
    sval     = neg_q ? -cy_q : cy_q;
    xsh      = cx_q >>> iter_q;
    ysh      = cy_q >>> iter_q;
    inc      = 28'((prod_q + 58'sd536870912) >>> 30);
    est_sum  = 34'(est_x_q) + 34'(inc);
    tsh      = $signed({8'd0, drtr_pkg::TwoPiQ} << k_q);
    ax       = (src_q == drtr_pkg::SrcEst) ? 33'(est_x_q) : 33'(odom_x_q);
    ay       = (src_q == drtr_pkg::SrcEst) ? 33'(est_y_q) : 33'(odom_y_q);
    dx       = ax - 33'(truth_x_q);
    dy       = ay - 33'(truth_y_q);
    acc_sum  = {1'b0, accum_q} + {17'd0, held_q};

    // Take configuration writes
    if (cfg_wr) begin
      if (paddr[2] == drtr_pkg::RegTimeStep) time_step_d = pwdata[23:0];
      else                                   src_d = pwdata[1:0];
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_take) begin
          unique case (in_word_i.mode)
            drtr_pkg::ModeVel: begin
              lin_d = in_word_i.lin_speed;
              ang_d = in_word_i.ang_speed;
              state_d = S_VMUL;
            end
            drtr_pkg::ModeOdom: begin
              odom_x_d = in_word_i.pos_x;
              odom_y_d = in_word_i.pos_y;
            end
            drtr_pkg::ModeTruth: begin
              truth_x_d = in_word_i.pos_x;
              truth_y_d = in_word_i.pos_y;
            end
            drtr_pkg::ModeTick: begin
              if (src_q == drtr_pkg::SrcEst || src_q == drtr_pkg::SrcOdom) state_d = S_TDIFF;
              else state_d = S_TACC;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      // Scale the speeds by the time step and fold the old heading
      S_VMUL: begin
        step_d = 25'((lin_prod + 49'sd8388608) >>> 24);
        dh_d   = 38'((ang_prod + 49'sd1024) >>> 11);
        cx_d   = drtr_pkg::CordicK;
        cy_d   = '0;
        iter_d = '0;
        if (hd_ext > drtr_pkg::HalfPiQ) begin
          cz_d = hd_ext - drtr_pkg::PiQ;  neg_d = 1'b1;
        end else if (hd_ext < -drtr_pkg::HalfPiQ) begin
          cz_d = hd_ext + drtr_pkg::PiQ;  neg_d = 1'b1;
        end else begin
          cz_d = hd_ext;  neg_d = 1'b0;
        end
        state_d = S_CORD;
      end
      // One rotation per cycle
      S_CORD: begin
        if (!cz_q[32]) begin
          cx_d = cx_q - ysh;  cy_d = cy_q + xsh;
          cz_d = cz_q - drtr_pkg::atan_entry(iter_q);
        end else begin
          cx_d = cx_q + ysh;  cy_d = cy_q - xsh;
          cz_d = cz_q + drtr_pkg::atan_entry(iter_q);
        end
        iter_d = iter_q + 5'd1;
        if (iter_q == drtr_pkg::CordicLast) state_d = S_MX;
      end
      S_MX: begin
        prod_d  = step_q * cval;
        state_d = S_MY;
      end
      S_MY: begin
        est_x_d = sat32(est_sum);
        prod_d  = step_q * sval;
        state_d = S_EY;
      end
      S_EY: begin
        est_y_d = sat32(34'(est_y_q) + 34'(inc));
        h_d = 40'(heading_q) + 40'(dh_q) + 40'(drtr_pkg::PiQ);
        state_d = S_HNEG;
      end
      // Lift a negative angle by a multiple of two pi
      S_HNEG: begin
        if (h_q[39]) h_d = h_q + $signed({8'd0, drtr_pkg::TwoPiQ} << 6);
        k_d = 3'd6;
        state_d = S_HRED;
      end
      // Restoring reduction modulo two pi
      S_HRED: begin
        h_d = (h_q >= tsh) ? h_q - tsh : h_q;
        k_d = k_q - 3'd1;
        if (k_q == 3'd0) begin
          heading_d = 32'(h_d - 40'(drtr_pkg::PiQ));
          state_d = S_IDLE;
        end
      end
      S_TDIFF: begin
        ux_d = dx[32] ? 32'(-dx) : dx[31:0];
        uy_d = dy[32] ? 32'(-dy) : dy[31:0];
        state_d = S_TSQX;
      end
      S_TSQX: begin
        sx_d = ux_q * ux_q;
        state_d = S_TSQY;
      end
      S_TSQY: begin
        n_d = {1'b0, sx_q} + {1'b0, 64'(uy_q) * 64'(uy_q)};
        state_d = S_TSTART;
      end
      S_TSTART: begin
        if (n_q[64]) begin
          held_d = 32'hFFFF_FFFF;
          state_d = S_TACC;
        end else begin
          sqrt_req.start = 1'b1;
          state_d = S_TROOT;
        end
      end
      S_TROOT: begin
        if (sqrt_rsp.done) begin
          held_d = sqrt_rsp.root;
          state_d = S_TACC;
        end
      end
      // Add to the total and emit once the output register is free, unless both speeds are zero
      S_TACC: begin
        if (lin_q == '0 && ang_q == '0) begin
          state_d = S_IDLE;
        end else if (!out_valid_q || !out_stall_i) begin
          accum_d = acc_sum[48] ? drtr_pkg::AccumMax : acc_sum[47:0];
          out_word_d.track_error = held_q;
          out_word_d.error_total = accum_d;
          out_valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      time_step_q <= drtr_pkg::TimeStepReset;
      src_q <= drtr_pkg::SourceReset;
      est_x_q <= '0;  est_y_q <= '0;  heading_q <= '0;
      lin_q <= '0;  ang_q <= '0;
      odom_x_q <= '0;  odom_y_q <= '0;  truth_x_q <= '0;  truth_y_q <= '0;
      held_q <= '0;  accum_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      time_step_q <= time_step_d;
      src_q <= src_d;
      est_x_q <= est_x_d;  est_y_q <= est_y_d;  heading_q <= heading_d;
      lin_q <= lin_d;  ang_q <= ang_d;
      odom_x_q <= odom_x_d;  odom_y_q <= odom_y_d;
      truth_x_q <= truth_x_d;  truth_y_q <= truth_y_d;
      held_q <= held_d;  accum_q <= accum_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold working values and the output word
  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
    step_q <= step_d;  dh_q <= dh_d;
    cx_q <= cx_d;  cy_q <= cy_d;  cz_q <= cz_d;  neg_q <= neg_d;  iter_q <= iter_d;
    prod_q <= prod_d;  h_q <= h_d;  k_q <= k_d;
    ux_q <= ux_d;  uy_q <= uy_d;  sx_q <= sx_d;  n_q <= n_d;
  end

endmodule

FILE: sv/drtr_checker.sv
// Port-level checks for the tracking-error block, bound to the top level.
module drtr_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input drtr_pkg::in_word_t  in_word_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input drtr_pkg::out_word_t out_word_o
);

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_word_o))
    else $error("stalled result changed");

  // Velocity and tick words keep the block busy for the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o &&
    (in_word_i.mode == drtr_pkg::ModeVel || in_word_i.mode == drtr_pkg::ModeTick)
    |=> in_stall_o)
    else $error("multi-cycle word did not stall input");

  // A new result never appears right after a word is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !$rose(out_valid_o))
    else $error("result too early after accept");

endmodule

bind dead_reckoning_tracking_error_top drtr_checker u_drtr_checker (.*);

FILE: dv/dead_reckoning_tracking_error_top_tb.sv
// Testbench for the dead-reckoning tracking-error monitor: directed table, random events, scoreboard.
`timescale 1ns / 100ps

module dead_reckoning_tracking_error_top_tb;

  localparam int RandomWords = 1620;
  localparam int DrainCycles = 200;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  drtr_pkg::in_word_t  in_word_i;
  logic                out_valid_o;
  logic                out_stall_i;
  drtr_pkg::out_word_t out_word_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [2:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  dead_reckoning_tracking_error_top DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_word_i,
    .out_valid_o, .out_stall_i, .out_word_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // Tracker state mirrored from the block
  logic [23:0]        trk_time_step;
  logic [1:0]         trk_source;
  logic signed [31:0] trk_est_x, trk_est_y, trk_heading;
  logic signed [23:0] trk_lin, trk_ang;
  logic signed [31:0] trk_odom_x, trk_odom_y, trk_truth_x, trk_truth_y;
  logic [31:0]        trk_held;
  logic [47:0]        trk_total;

  drtr_pkg::out_word_t expected_words[$];
  int        fail_count;
  int        result_count;
  int        tick_count;
  bit        rx_idle_on;
  bit        hold_off;

  // Directed row: word plus optional typed expectation
  typedef struct {
    drtr_pkg::in_word_t  word;
    bit                  has_typed;
    drtr_pkg::out_word_t typed;
  } table_row_t;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("dead_reckoning_tracking_error_top test failed");
    $finish;
  end

  function automatic longint floor_div_pow2(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint round_pow2(longint v, int n);
    return (v + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint atan_q(int i);
    longint tab[24] = '{421657428, 248918915, 131521918, 66762579, 33510843, 16771758,
                        8387925, 4194219, 2097141, 1048575, 524288, 262144,
                        131072, 65536, 32768, 16384, 8192, 4096,
                        2048, 1024, 512, 256, 128, 64};
    return tab[i];
  endfunction

  // Rotation-mode CORDIC on the heading, folded into the right half-plane
  task automatic rotate_heading(input longint ang, output longint c, output longint s);
    longint x, y, z, nx;
    bit     flip;
    x = 652032874; y = 0; z = ang; flip = 0;
    if (z > 843314857) begin z -= 1686629713; flip = 1; end
    else if (z < -843314857) begin z += 1686629713; flip = 1; end
    for (int i = 0; i < 24; i++) begin
      if (z >= 0) begin
        nx = x - floor_div_pow2(y, i); y = y + floor_div_pow2(x, i); z -= atan_q(i);
      end else begin
        nx = x + floor_div_pow2(y, i); y = y - floor_div_pow2(x, i); z += atan_q(i);
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  // Exact integer distance, saturated to 32 bits
  function automatic logic [31:0] gap_length(logic signed [31:0] ax, logic signed [31:0] ay,
                                             logic signed [31:0] bx, logic signed [31:0] by);
    longint     dx, dy;
    logic [64:0] n, res, bitv;
    dx = longint'(ax) - longint'(bx);
    dy = longint'(ay) - longint'(by);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    n = 65'(dx) * 65'(dx) + 65'(dy) * 65'(dy);
    res = 0;
    bitv = 65'd1 << 64;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv; res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return (res > 65'hFFFFFFFF) ? 32'hFFFFFFFF : res[31:0];
  endfunction

  // Advance the tracker by one word, queueing any result it produces
  task automatic track_word(input drtr_pkg::in_word_t w);
    longint    c, s, step, h;
    logic [48:0] sum;
    drtr_pkg::out_word_t r;
    case (w.mode)
      drtr_pkg::ModeVel: begin
        trk_lin = w.lin_speed;
        trk_ang = w.ang_speed;
        rotate_heading(longint'(trk_heading), c, s);
        step = round_pow2(longint'(w.lin_speed) * longint'(trk_time_step), 24);
        trk_est_x = clamp32(longint'(trk_est_x) + round_pow2(step * c, 30));
        trk_est_y = clamp32(longint'(trk_est_y) + round_pow2(step * s, 30));
        h = longint'(trk_heading) + round_pow2(longint'(w.ang_speed) * longint'(trk_time_step), 11)
            + 1686629713;
        h = h % 64'sd3373259426;
        if (h < 0) h += 64'sd3373259426;
        trk_heading = 32'(h - 1686629713);
      end
      drtr_pkg::ModeOdom: begin
        trk_odom_x = w.pos_x; trk_odom_y = w.pos_y;
      end
      drtr_pkg::ModeTruth: begin
        trk_truth_x = w.pos_x; trk_truth_y = w.pos_y;
      end
      default: begin
        if (trk_source == drtr_pkg::SrcEst)
          trk_held = gap_length(trk_est_x, trk_est_y, trk_truth_x, trk_truth_y);
        else if (trk_source == drtr_pkg::SrcOdom)
          trk_held = gap_length(trk_odom_x, trk_odom_y, trk_truth_x, trk_truth_y);
        if (trk_lin != 0 || trk_ang != 0) begin
          sum = {1'b0, trk_total} + 49'(trk_held);
          trk_total = sum[48] ? drtr_pkg::AccumMax : sum[47:0];
          r.track_error = trk_held;
          r.error_total = trk_total;
          expected_words.push_back(r);
        end
      end
    endcase
  endtask

  // Compare each delivered result with the oldest expectation
  always @(posedge clk_i) begin
    drtr_pkg::out_word_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      result_count++;
      if (expected_words.size() == 0) begin
        $error("result with no expectation: track_error %0h error_total %0h",
               out_word_o.track_error, out_word_o.error_total);
        fail_count++;
      end else begin
        e = expected_words.pop_front();
        if (out_word_o.track_error !== e.track_error) begin
          $error("track_error expected %0h actual %0h", e.track_error, out_word_o.track_error);
          fail_count++;
        end
        if (out_word_o.error_total !== e.error_total) begin
          $error("error_total expected %0h actual %0h", e.error_total, out_word_o.error_total);
          fail_count++;
        end
      end
    end
  end

  // Receiver: random stall bursts, one long hold-off, none at the end
  initial begin
    int n;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        out_stall_i <= 1'b1;
        repeat (300) @(negedge clk_i);
        hold_off = 0;
        out_stall_i <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 4);
        out_stall_i <= 1'b1;
        repeat (n) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Register write through setup and access cycles
  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr[2] == drtr_pkg::RegSourceSelect) trk_source = data[1:0];
    else trk_time_step = data[23:0];
  endtask

  // Offer one word, with an optional gap before it, and wait for acceptance
  task automatic send_word(input drtr_pkg::in_word_t w, input bit gaps);
    if (gaps && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    track_word(w);
    @(negedge clk_i);
  endtask

  task automatic settle;
    in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  function automatic drtr_pkg::in_word_t make_word(logic [1:0] m, int v, int a, int x, int y);
    drtr_pkg::in_word_t w;
    w.mode = m; w.lin_speed = 24'(v); w.ang_speed = 24'(a);
    w.pos_x = x; w.pos_y = y;
    return w;
  endfunction

  function automatic drtr_pkg::in_word_t random_word();
    drtr_pkg::in_word_t w;
    logic [127:0]       rbits;
    int                 k;
    rbits = {$urandom, $urandom, $urandom, $urandom};
    w = rbits[$bits(drtr_pkg::in_word_t)-1:0];
    k = $urandom_range(0, 9);
    // Mostly modest motion and positions, with full-range words mixed in
    if (k < 7) begin
      w.lin_speed = 24'($signed($urandom_range(0, 400000)) - 200000);
      w.ang_speed = 24'($signed($urandom_range(0, 400000)) - 200000);
      w.pos_x = $signed($urandom_range(0, 40000000)) - 20000000;
      w.pos_y = $signed($urandom_range(0, 40000000)) - 20000000;
    end
    k = $urandom_range(0, 9);
    w.mode = (k < 4) ? drtr_pkg::ModeVel : (k < 5) ? drtr_pkg::ModeOdom :
             (k < 7) ? drtr_pkg::ModeTruth : drtr_pkg::ModeTick;
    return w;
  endfunction

  initial begin
    table_row_t rows[$];
    table_row_t row;
    logic [23:0] steps[4];
    drtr_pkg::in_word_t w;
    fail_count = 0; result_count = 0; tick_count = 0;
    rx_idle_on = 0; hold_off = 0;
    rst_ni = 1'b0; in_valid_i = 1'b0; in_word_i = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    trk_time_step = drtr_pkg::TimeStepReset; trk_source = drtr_pkg::SourceReset;
    trk_est_x = 0; trk_est_y = 0; trk_heading = 0; trk_lin = 0; trk_ang = 0;
    trk_odom_x = 0; trk_odom_y = 0; trk_truth_x = 0; trk_truth_y = 0;
    trk_held = 0; trk_total = 0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed table; typed expectations where obvious
    row.has_typed = 0; row.typed = '0;
    row.word = make_word(drtr_pkg::ModeTick, 0, 0, 0, 0);
    rows.push_back(row);   // zero velocity: silent
    row.word = make_word(drtr_pkg::ModeTruth, 0, 0, 3 << 16, 4 << 16); rows.push_back(row);
    row.word = make_word(drtr_pkg::ModeVel, 0, 1, 0, 0); rows.push_back(row);
    row.has_typed = 1; row.typed = {32'h0005_0000, 48'h5_0000};
    row.word = make_word(drtr_pkg::ModeTick, 0, 0, 0, 0); rows.push_back(row);
    row.has_typed = 0;
    row.word = make_word(drtr_pkg::ModeVel, 8388607, 8388607, 0, 0); rows.push_back(row);
    row.word = make_word(drtr_pkg::ModeVel, -8388608, -8388608, 0, 0); rows.push_back(row);
    row.word = make_word(drtr_pkg::ModeTick, 0, 0, 0, 0); rows.push_back(row);
    row.word = make_word(drtr_pkg::ModeOdom, 0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF);
    rows.push_back(row);
    row.word = make_word(drtr_pkg::ModeTruth, 0, 0, 32'h80000000, 32'h80000000);
    rows.push_back(row);
    row.word = make_word(drtr_pkg::ModeTick, 0, 0, 0, 0); rows.push_back(row);
    row.word = make_word(drtr_pkg::ModeVel, 65536, -65536, -1, -1); rows.push_back(row);
    row.word = make_word(drtr_pkg::ModeTick, 0, 0, 0, 0); rows.push_back(row);
    foreach (rows[i]) begin
      send_word(rows[i].word, 0);
      if (rows[i].has_typed && expected_words.size() != 0) begin
        if (expected_words[$].track_error !== rows[i].typed.track_error) begin
          $error("track_error expected %0h actual %0h", rows[i].typed.track_error,
                 expected_words[$].track_error);
          fail_count++;
        end
        if (expected_words[$].error_total !== rows[i].typed.error_total) begin
          $error("error_total expected %0h actual %0h", rows[i].typed.error_total,
                 expected_words[$].error_total);
          fail_count++;
        end
      end
      if (rows[i].word.mode == drtr_pkg::ModeTick) tick_count++;
    end
    settle();

    // Odometry source with huge distance, then repeated to grow the total
    reg_write(3'h4, {30'd0, drtr_pkg::SrcOdom});
    for (int i = 0; i < 4; i++) begin
      send_word(make_word(drtr_pkg::ModeTick, 0, 0, 0, 0), 0);
      tick_count++;
    end
    settle();
    reg_write(3'h4, 32'd3);   // code three holds like zero
    send_word(make_word(drtr_pkg::ModeTick, 0, 0, 0, 0), 0);
    tick_count++;
    settle();

    // Random phases over several time steps and sources
    rx_idle_on = 1;
    steps[0] = 24'hFFFFFF; steps[1] = 24'd0; steps[2] = drtr_pkg::TimeStepReset;
    steps[3] = 24'd100000;
    for (int ph = 0; ph < 6; ph++) begin
      reg_write(3'h0, (ph < 4) ? {8'd0, steps[ph]} : {8'd0, 24'($urandom)});
      reg_write(3'h4, 32'(ph % 4));
      for (int i = 0; i < RandomWords / 6; i++) begin
        if (ph == 1 && i == 20) hold_off = 1;
        if (ph == 5 && i > RandomWords / 12) rx_idle_on = 0;
        w = random_word();
        if (w.mode == drtr_pkg::ModeTick) tick_count++;
        send_word(w, ph != 5 || i < RandomWords / 12);
      end
      settle();
    end
    in_valid_i <= 1'b0;
    repeat (DrainCycles) @(negedge clk_i);

    $display("Covered %0d ticks, %0d results checked across six register settings.",
             tick_count, result_count);
    if (fail_count == 0 && expected_words.size() == 0) begin
      $display("dead_reckoning_tracking_error_top test passed");
    end else begin
      if (expected_words.size() != 0)
        $error("%0d expected results never arrived", expected_words.size());
      $display("dead_reckoning_tracking_error_top test failed");
    end
    $finish;
  end

endmodule
